// File: rtl/gm3_pkg.sv
// ----------------------------------------------------------------------------
// gm3_pkg: shared types and constants for the 3x3 grayscale morphology core
// Pixel, address and dimension types, register indexes and the stage item.
// ----------------------------------------------------------------------------
package gm3_pkg;

  localparam int unsigned PIXEL_BITS     = 8;
  localparam int unsigned MAX_WIDTH      = 1024;
  localparam int unsigned MAX_HEIGHT     = 1024;
  localparam int unsigned ADDR_BITS      = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_BITS       = $clog2(MAX_HEIGHT);
  localparam int unsigned DIM_BITS       = 11;
  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS  = 11;

  // Register indexes of the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HEIGHT = 2'd2;

  // Operation codes of the mode register
  localparam logic MODE_ERODE  = 1'b0;
  localparam logic MODE_DILATE = 1'b1;

  typedef logic [PIXEL_BITS-1:0] pixel_t;
  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [ROW_BITS-1:0]   row_t;
  typedef logic [DIM_BITS-1:0]   dim_t;

  localparam dim_t MAX_WIDTH_DIM  = DIM_BITS'(MAX_WIDTH);
  localparam dim_t MAX_HEIGHT_DIM = DIM_BITS'(MAX_HEIGHT);
  localparam dim_t ROW_LIMIT      = 11'd2047;
  localparam dim_t WIDTH_RESET    = 11'd640;
  localparam dim_t HEIGHT_RESET   = 11'd480;

  // One line store entry: pixel two lines up and one line up
  typedef struct packed {
    pixel_t two_up;
    pixel_t one_up;
  } line_word_t;

  // Item handed from the counter stage to the window stage
  typedef struct packed {
    addr_t  addr;
    pixel_t bot;
    logic   emit;
    logic   interior;
    logic   eol;
    logic   eof;
  } item_t;

endpackage

// File: rtl/gm3_line_ram.sv
// ----------------------------------------------------------------------------
// gm3_line_ram: line store for the two previous lines
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module gm3_line_ram (
  input  logic                clk_i,
  input  logic                re_i,
  input  gm3_pkg::addr_t      raddr_i,
  output gm3_pkg::line_word_t rdata_o,
  input  logic                we_i,
  input  gm3_pkg::addr_t      waddr_i,
  input  gm3_pkg::line_word_t wdata_i
);

  gm3_pkg::line_word_t mem [gm3_pkg::MAX_WIDTH];
  gm3_pkg::line_word_t rdata_q;

  // Write and read; a read of the entry being written returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/gm3_ctrl.sv
// ----------------------------------------------------------------------------
// gm3_ctrl: configuration registers and raster position counters
// Classifies each incoming transaction and advances the input/output counters.
// ----------------------------------------------------------------------------
module gm3_ctrl (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [gm3_pkg::CFG_INDEX_BITS-1:0]     cfg_index_i,
  input  logic [gm3_pkg::CFG_DATA_BITS-1:0]      cfg_wdata_i,
  input  logic                                   accept_i,
  input  gm3_pkg::pixel_t                        pixel_i,
  output gm3_pkg::item_t                         item_o,
  output logic                                   mode_o
);

  logic          mode_q;
  gm3_pkg::dim_t width_q;
  gm3_pkg::dim_t height_q;

  gm3_pkg::addr_t in_col_q,  in_col_d;
  gm3_pkg::dim_t  in_row_q,  in_row_d;
  gm3_pkg::addr_t out_col_q, out_col_d;
  gm3_pkg::row_t  out_row_q, out_row_d;

  gm3_pkg::dim_t w_eff;
  gm3_pkg::dim_t h_eff;
  gm3_pkg::dim_t in_col_inc;
  gm3_pkg::dim_t out_col_inc;
  gm3_pkg::dim_t out_row_inc;
  logic          emit;
  logic          eol;
  logic          eof;
  logic          interior;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= gm3_pkg::MODE_ERODE;
      width_q  <= gm3_pkg::WIDTH_RESET;
      height_q <= gm3_pkg::HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        gm3_pkg::CFG_MODE:   mode_q   <= cfg_wdata_i[0];
        gm3_pkg::CFG_WIDTH:  width_q  <= cfg_wdata_i;
        gm3_pkg::CFG_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign mode_o = mode_q;

  // Clamp frame sizes to the supported range
  always_comb begin
    if (width_q == '0) begin
      w_eff = gm3_pkg::DIM_BITS'(1);
    end else if (width_q > gm3_pkg::MAX_WIDTH_DIM) begin
      w_eff = gm3_pkg::MAX_WIDTH_DIM;
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = gm3_pkg::DIM_BITS'(1);
    end else if (height_q > gm3_pkg::MAX_HEIGHT_DIM) begin
      h_eff = gm3_pkg::MAX_HEIGHT_DIM;
    end else begin
      h_eff = height_q;
    end
  end

  // Classify the current transaction against the output position
  always_comb begin
    in_col_inc  = gm3_pkg::DIM_BITS'(in_col_q) + gm3_pkg::DIM_BITS'(1);
    out_col_inc = gm3_pkg::DIM_BITS'(out_col_q) + gm3_pkg::DIM_BITS'(1);
    out_row_inc = gm3_pkg::DIM_BITS'(out_row_q) + gm3_pkg::DIM_BITS'(1);
    emit        = (in_row_q >= gm3_pkg::DIM_BITS'(2)) ||
                  ((in_row_q == gm3_pkg::DIM_BITS'(1)) && (in_col_q != '0));
    eol         = emit && (out_col_inc >= w_eff);
    eof         = eol && (out_row_inc >= h_eff);
    interior    = (out_row_q != '0) && (out_row_inc < h_eff) &&
                  (out_col_q != '0) && (out_col_inc < w_eff);

    item_o.addr     = in_col_q;
    item_o.bot      = (in_row_q < h_eff) ? pixel_i : '0;
    item_o.emit     = emit;
    item_o.interior = interior;
    item_o.eol      = eol;
    item_o.eof      = eof;
  end

  // Advance the counters; end of frame returns all of them to zero
  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (accept_i) begin
      if (eof) begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
      end else begin
        if (in_col_inc >= w_eff) begin
          in_col_d = '0;
          if (in_row_q < gm3_pkg::ROW_LIMIT) begin
            in_row_d = in_row_q + gm3_pkg::DIM_BITS'(1);
          end
        end else begin
          in_col_d = in_col_inc[gm3_pkg::ADDR_BITS-1:0];
        end
        if (emit) begin
          if (eol) begin
            out_col_d = '0;
            out_row_d = out_row_inc[gm3_pkg::ROW_BITS-1:0];
          end else begin
            out_col_d = out_col_inc[gm3_pkg::ADDR_BITS-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  // A frame end leaves every counter at the frame origin
  a_eof_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && item_o.eof) |=>
      (in_col_q == '0 && in_row_q == '0 && out_col_q == '0 && out_row_q == '0))
    else $error("counters not cleared after end of frame");

endmodule

// File: rtl/gm3_window.sv
// ----------------------------------------------------------------------------
// gm3_window: line store update, 3x3 window and result register
// Merges line store data with forwarding, shifts the window, picks min or max.
// ----------------------------------------------------------------------------
module gm3_window (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  gm3_pkg::item_t      item_i,
  input  logic                mode_i,
  input  gm3_pkg::line_word_t rd_data_i,
  output logic                ready_o,
  output logic                mem_we_o,
  output gm3_pkg::addr_t      mem_waddr_o,
  output gm3_pkg::line_word_t mem_wdata_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output gm3_pkg::pixel_t     result_pixel_o,
  output logic                end_of_line_o,
  output logic                end_of_frame_o
);

  logic                s1_valid_q;
  gm3_pkg::item_t      s1_q;
  logic                fwd_q;
  gm3_pkg::line_word_t fwd_data_q;
  logic                fwd_d;
  logic                s1_adv;

  gm3_pkg::line_word_t line_word;
  gm3_pkg::pixel_t     win_q [6];
  gm3_pkg::pixel_t     taps  [9];
  gm3_pkg::pixel_t     acc;
  gm3_pkg::pixel_t     value;

  logic            out_valid_q;
  gm3_pkg::pixel_t out_pixel_q;
  logic            out_eol_q;
  logic            out_eof_q;

  // Advance the window stage unless its result would overwrite a waiting one
  always_comb begin
    s1_adv  = s1_valid_q && (!s1_q.emit || !out_valid_q || out_ready_i);
    ready_o = !s1_valid_q || s1_adv;
  end

  // Take forwarded data when the previous transaction wrote the same entry
  always_comb begin
    line_word   = fwd_q ? fwd_data_q : rd_data_i;
    mem_we_o    = s1_adv;
    mem_waddr_o = s1_q.addr;
    mem_wdata_o.two_up = line_word.one_up;
    mem_wdata_o.one_up = s1_q.bot;
    fwd_d       = mem_we_o && (mem_waddr_o == item_i.addr);
  end

  // Find the window minimum or maximum
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      taps[i] = win_q[i];
    end
    taps[6] = line_word.two_up;
    taps[7] = line_word.one_up;
    taps[8] = s1_q.bot;
    acc = taps[0];
    for (int i = 1; i < 9; i++) begin
      if (mode_i == gm3_pkg::MODE_DILATE) begin
        if (taps[i] > acc) acc = taps[i];
      end else begin
        if (taps[i] < acc) acc = taps[i];
      end
    end
    if (s1_q.interior) begin
      value = acc;
    end else if (mode_i == gm3_pkg::MODE_DILATE) begin
      value = win_q[4];
    end else begin
      value = '0;
    end
  end

  // Hold the stage valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else if (accept_i) begin
      s1_valid_q <= 1'b1;
      fwd_q      <= fwd_d;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Capture the stage payload on each accepted transaction
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_q       <= item_i;
      fwd_data_q <= mem_wdata_o;
    end
  end

  // Shift the window by one column per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_adv) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= line_word.two_up;
      win_q[4] <= line_word.one_up;
      win_q[5] <= s1_q.bot;
    end
  end

  // Load the result register, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_q.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_q.emit) begin
      out_pixel_q <= value;
      out_eol_q   <= s1_q.eol;
      out_eof_q   <= s1_q.eof;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_pixel_o = out_pixel_q;
  assign end_of_line_o  = out_eol_q;
  assign end_of_frame_o = out_eof_q;

  // A frame end is always also a line end
  a_eof_is_eol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_eof_q |-> out_eol_q)
    else $error("end of frame without end of line");

  // An interior result is bounded by the window center
  a_center_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_q.emit && s1_q.interior) |->
      ((mode_i == gm3_pkg::MODE_DILATE) ? (value >= win_q[4]) : (value <= win_q[4])))
    else $error("window result not bounded by center pixel");

endmodule

// File: rtl/gray_morphology_3x3_core.sv
// ----------------------------------------------------------------------------
// gray_morphology_3x3_core: streaming 3x3 grayscale erosion / dilation
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   pixel_i
//   out      output     out_valid_o / out_ready_i result_pixel_o, end_of_line_o,
//                                                 end_of_frame_o
//   cfg      input      cfg_we_i (no wait)        cfg_index_i, cfg_wdata_i
//
// One pixel per clock sustained while the output is taken; the line store
// read-modify-write is the loop, with forwarding between consecutive
// transactions on the same entry. A result passes the window stage register
// into the result register, which holds it until it is taken.
// Reset clears counters, window and handshake state; the line store is not
// cleared (the first frame's top rows only feed border results).
// A stalled output holds the result register; the input keeps being taken
// until the window stage is also occupied by a result-producing transaction.
// ----------------------------------------------------------------------------
module gray_morphology_3x3_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [gm3_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [gm3_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  gm3_pkg::pixel_t                    pixel_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output gm3_pkg::pixel_t                    result_pixel_o,
  output logic                               end_of_line_o,
  output logic                               end_of_frame_o
);

  logic                accept;
  gm3_pkg::item_t      item;
  logic                mode;
  gm3_pkg::line_word_t rd_data;
  logic                mem_we;
  gm3_pkg::addr_t      mem_waddr;
  gm3_pkg::line_word_t mem_wdata;

  assign accept = in_valid_i && in_ready_o;

  // Counters and configuration
  gm3_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .pixel_i     (pixel_i),
    .item_o      (item),
    .mode_o      (mode)
  );

  // Line store, read on each accepted transaction
  gm3_line_ram u_line_ram (
    .clk_i   (clk_i),
    .re_i    (accept),
    .raddr_i (item.addr),
    .rdata_o (rd_data),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata)
  );

  // Window and result register
  gm3_window u_window (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .item_i         (item),
    .mode_i         (mode),
    .rd_data_i      (rd_data),
    .ready_o        (in_ready_o),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_pixel_o (result_pixel_o),
    .end_of_line_o  (end_of_line_o),
    .end_of_frame_o (end_of_frame_o)
  );

endmodule
